[rtl/fqs_pkg.sv]
// Shared constants, payload types and control types of the searchable queue.
`default_nettype none
package fqs_pkg;

   localparam int DEPTH  = 16;
   localparam int DATA_W = 32;
   localparam int IDX_W  = $clog2(DEPTH);
   localparam int CNT_W  = $clog2(DEPTH + 1);

   localparam logic [IDX_W-1:0] IDX_LAST = IDX_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   // Operation codes carried in the request.
   localparam logic [1:0] OP_PUSH   = 2'd0;
   localparam logic [1:0] OP_POP    = 2'd1;
   localparam logic [1:0] OP_SEARCH = 2'd2;

   typedef struct packed {
      logic [1:0]               op;
      logic signed [DATA_W-1:0] value;
   } req_type;

   typedef struct packed {
      logic                     ok;
      logic signed [DATA_W-1:0] popped_value;
      logic [CNT_W-1:0]         position;
      logic signed [DATA_W-1:0] head_value;
      logic                     head_valid;
      logic                     is_empty;
      logic [CNT_W-1:0]         occupancy;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EXEC,
      ST_POP_WAIT,
      ST_SRCH_RD,
      ST_SRCH_CMP,
      ST_HEAD_RD,
      ST_DONE
   } ctl_state_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic do_push;
      logic rd_head;
      logic pop_commit;
      logic srch_init;
      logic srch_rd;
      logic srch_hit;
      logic srch_step;
      logic load_rsp;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic [1:0] op;
      logic       full;
      logic       empty;
      logic       match;
      logic       last;
   } sts_type;

endpackage
`default_nettype wire

[rtl/fqs_req_if.sv]
// Request channel of the searchable queue: valid, ready and one request.
`default_nettype none
interface fqs_req_if;
   import fqs_pkg::*;

   logic    valid;
   logic    ready;
   req_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/fqs_rsp_if.sv]
// Response channel of the searchable queue: valid, ready and one response.
`default_nettype none
interface fqs_rsp_if;
   import fqs_pkg::*;

   logic    valid;
   logic    ready;
   rsp_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/fifo_queue_with_search.sv]
// Top level of the searchable queue: joins the controller and the datapath to the channels.
//
// The block is a first-in first-out queue of 16 signed 32-bit values. Each request
// transfer on req_if carries an op (push, pop or search) and a value. Every request
// gives exactly one response transfer on rsp_if with ok, the popped value, the
// one-based search position, and the head value, head valid flag, empty flag and
// occupancy as they stand after the request.
// Requests are worked one at a time. After the request is accepted in idle, a push,
// an unused op, or a pop or search on an empty queue passes through exec, head read
// and done; a pop of a held entry through exec, pop wait, head read and done; and a
// search through exec, then a read and a compare state for each entry compared, up to
// the match or, with no match, over every entry held, then head read and done. The
// single read port of the ring store sets this order, and the new head is read back
// once per request. The response register is loaded in done, and the controller then
// returns to idle before it takes the next request.
// The response sits in an output register, so the next request is taken while a
// response still waits; if the receiver stalls, that next request finishes its work
// and then holds until the waiting response has been transferred.
// Synchronous reset empties the queue and drops any pending response; the store
// contents are not cleared, since only held entries ever reach a response.
`default_nettype none
module fifo_queue_with_search (
   input wire logic  clock,
   input wire logic  reset,
   fqs_req_if.sink   req_if,
   fqs_rsp_if.source rsp_if
);
   import fqs_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // The controller decides what happens in each cycle and owns both handshakes.
   fqs_controller u_controller (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_ready (req_if.ready),
      .rsp_valid (rsp_if.valid),
      .rsp_ready (rsp_if.ready),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds the ring store, pointers, count and the response register.
   fqs_datapath u_datapath (
      .clock    (clock),
      .reset    (reset),
      .req_data (req_if.data),
      .cmd      (cmd),
      .sts      (sts),
      .rsp_data (rsp_if.data)
   );

endmodule
`default_nettype wire

[rtl/fqs_datapath.sv]
// Datapath of the searchable queue: ring store, pointers, search counter, response register.
`default_nettype none
module fqs_datapath (
   input  wire logic            clock,
   input  wire logic            reset,
   input  wire fqs_pkg::req_type req_data,
   input  wire fqs_pkg::cmd_type cmd,
   output fqs_pkg::sts_type      sts,
   output fqs_pkg::rsp_type      rsp_data
);
   import fqs_pkg::*;

   logic signed [DATA_W-1:0] entries_ff [DEPTH];
   logic signed [DATA_W-1:0] rdata_ff;

   logic [1:0]               op_ff;
   logic signed [DATA_W-1:0] value_ff;
   logic [IDX_W-1:0]         head_ff, head_in;
   logic [IDX_W-1:0]         tail_ff, tail_in;
   logic [CNT_W-1:0]         count_ff, count_in;
   logic [IDX_W-1:0]         slot_ff, slot_in;
   logic [CNT_W-1:0]         k_ff, k_in;
   logic                     ok_ff, ok_in;
   logic signed [DATA_W-1:0] popped_ff, popped_in;
   logic [CNT_W-1:0]         pos_ff, pos_in;
   rsp_type                  rsp_ff, rsp_in;

   logic                     rd_en;
   logic [IDX_W-1:0]         rd_addr;
   logic [CNT_W-1:0]         k_plus;

   function automatic logic [IDX_W-1:0] next_slot(input logic [IDX_W-1:0] slot);
      next_slot = (slot == IDX_LAST) ? '0 : slot + IDX_W'(1);
   endfunction

   assign k_plus  = k_ff + CNT_W'(1);
   assign rd_en   = cmd.rd_head | cmd.srch_rd;
   assign rd_addr = cmd.srch_rd ? slot_ff : head_ff;

   // Ring store: one write port at the tail, one registered read port.
   always_ff @(posedge clock) begin
      if (cmd.do_push) begin
         entries_ff[tail_ff] <= value_ff;
      end
      if (rd_en) begin
         rdata_ff <= entries_ff[rd_addr];
      end
   end

   always_comb begin
      head_in   = head_ff;
      tail_in   = tail_ff;
      count_in  = count_ff;
      slot_in   = slot_ff;
      k_in      = k_ff;
      ok_in     = ok_ff;
      popped_in = popped_ff;
      pos_in    = pos_ff;
      rsp_in    = rsp_ff;

      if (cmd.capture) begin
         ok_in     = 1'b0;
         popped_in = '0;
         pos_in    = '0;
      end
      if (cmd.do_push) begin
         tail_in  = next_slot(tail_ff);
         count_in = count_ff + CNT_W'(1);
         ok_in    = 1'b1;
      end
      if (cmd.pop_commit) begin
         popped_in = rdata_ff;
         head_in   = next_slot(head_ff);
         count_in  = count_ff - CNT_W'(1);
         ok_in     = 1'b1;
      end
      if (cmd.srch_init) begin
         slot_in = head_ff;
         k_in    = '0;
      end
      if (cmd.srch_step) begin
         slot_in = next_slot(slot_ff);
         k_in    = k_plus;
      end
      if (cmd.srch_hit) begin
         pos_in = k_plus;
         ok_in  = 1'b1;
      end
      if (cmd.load_rsp) begin
         rsp_in.ok           = ok_ff;
         rsp_in.popped_value = popped_ff;
         rsp_in.position     = pos_ff;
         rsp_in.head_value   = (count_ff != '0) ? rdata_ff : '0;
         rsp_in.head_valid   = (count_ff != '0);
         rsp_in.is_empty     = (count_ff == '0);
         rsp_in.occupancy    = count_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff  <= '0;
         tail_ff  <= '0;
         count_ff <= '0;
      end else begin
         head_ff  <= head_in;
         tail_ff  <= tail_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff    <= req_data.op;
         value_ff <= req_data.value;
      end
      slot_ff   <= slot_in;
      k_ff      <= k_in;
      ok_ff     <= ok_in;
      popped_ff <= popped_in;
      pos_ff    <= pos_in;
      rsp_ff    <= rsp_in;
   end

   always_comb begin
      sts.op    = op_ff;
      sts.full  = (count_ff == CNT_FULL);
      sts.empty = (count_ff == '0);
      sts.match = (rdata_ff == value_ff);
      sts.last  = (k_plus == count_ff);
   end

   assign rsp_data = rsp_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_FULL)
      else $error("queue count exceeds depth");

   a_ptr_agree: assert property (@(posedge clock) disable iff (reset)
      (count_ff == '0 || count_ff == CNT_FULL) |-> (head_ff == tail_ff))
      else $error("head and tail disagree with an empty or full queue");

   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop_commit |-> (count_ff != '0))
      else $error("pop committed on an empty queue");

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      cmd.do_push |-> (count_ff != CNT_FULL))
      else $error("push written into a full queue");
`endif

endmodule
`default_nettype wire

[rtl/fqs_controller.sv]
// Controller of the searchable queue: sequences each request and owns the handshakes.
`default_nettype none
module fqs_controller (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_ready,
   output logic                  rsp_valid,
   input  wire logic             rsp_ready,
   input  wire fqs_pkg::sts_type sts,
   output fqs_pkg::cmd_type      cmd
);
   import fqs_pkg::*;

   ctl_state_type state_ff, state_in;
   logic          rsp_valid_ff, rsp_valid_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            // Nothing is taken while reset is held, so no transfer is lost.
            req_ready = !reset;
            if (req_valid && !reset) begin
               cmd.capture = 1'b1;
               state_in    = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = ST_HEAD_RD;
            unique case (sts.op)
               OP_PUSH: begin
                  cmd.do_push = !sts.full;
               end
               OP_POP: begin
                  if (!sts.empty) begin
                     cmd.rd_head = 1'b1;
                     state_in    = ST_POP_WAIT;
                  end
               end
               OP_SEARCH: begin
                  if (!sts.empty) begin
                     cmd.srch_init = 1'b1;
                     state_in      = ST_SRCH_RD;
                  end
               end
               default: begin
                  state_in = ST_HEAD_RD;
               end
            endcase
         end
         ST_POP_WAIT: begin
            cmd.pop_commit = 1'b1;
            state_in       = ST_HEAD_RD;
         end
         ST_SRCH_RD: begin
            cmd.srch_rd = 1'b1;
            state_in    = ST_SRCH_CMP;
         end
         ST_SRCH_CMP: begin
            priority if (sts.match) begin
               cmd.srch_hit = 1'b1;
               state_in     = ST_HEAD_RD;
            end else if (sts.last) begin
               state_in = ST_HEAD_RD;
            end else begin
               cmd.srch_step = 1'b1;
               state_in      = ST_SRCH_RD;
            end
         end
         ST_HEAD_RD: begin
            cmd.rd_head = 1'b1;
            state_in    = ST_DONE;
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      if (cmd.load_rsp) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end else begin
         rsp_valid_in = rsp_valid_ff;
      end
   end

   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTHESIS
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.load_rsp |-> (!rsp_valid_ff || rsp_ready))
      else $error("response register loaded over an untaken response");

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == ST_EXEC))
      else $error("accepted request did not start execution");

   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (state_ff == ST_IDLE && !cmd.load_rsp))
      else $error("request taken while another is in progress");
`endif

endmodule
`default_nettype wire

[dv/testbench.sv]
// Self-checking testbench of the searchable queue: directed table, then random traffic.
`default_nettype none
module testbench;
   import fqs_pkg::*;

   // The package names push, pop and search only. The fourth code does nothing
   // in the block, but the block still answers it with a status transfer.
   localparam logic [1:0] OP_UNUSED = 2'd3;

   localparam logic signed [DATA_W-1:0] MAX_VALUE = 32'sh7FFF_FFFF;
   localparam logic signed [DATA_W-1:0] MIN_VALUE = 32'sh8000_0000;
   localparam logic signed [DATA_W-1:0] ALL_ONES  = -32'sd1;

   localparam int RANDOM_ITEMS  = 1700;
   localparam int HOLD_CYCLES   = 250;   // long receiver hold-off
   localparam int HOLD_AFTER    = 300;   // responses received before the hold-off
   localparam int DRAIN_CYCLES  = 60;    // settle time after the last response
   localparam int STALL_LIMIT   = 5000;  // cycles with no transfer on any channel

   typedef enum int {MODE_FILL, MODE_DRAIN, MODE_MIX} traffic_mode_type;

   // One row of the directed table. A row with has_want set carries the
   // response typed in by hand; every other row is checked against the
   // predictor. A row with reps above one sends the same request repeatedly.
   typedef struct {
      req_type item;
      int      reps;
      bit      has_want;
      rsp_type want;
   } stim_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   fqs_req_if req_ch ();
   fqs_rsp_if rsp_ch ();

   fifo_queue_with_search dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req_ch),
      .rsp_if (rsp_ch)
   );

   always #5 clock = ~clock;

   // Shadow copy of the queue kept by the predictor.
   logic signed [DATA_W-1:0] ring [DEPTH];
   int unsigned              ring_head  = 0;
   int unsigned              ring_tail  = 0;
   int unsigned              ring_count = 0;

   rsp_type      due_responses [$];
   stim_row_type directed_rows [$];

   int error_count   = 0;
   int req_gap_pct   = 20;   // chance in percent that the sender idles a cycle
   int rsp_stall_pct = 20;   // chance in percent that the receiver stalls a cycle
   int rsp_transfers = 0;
   int quiet_cycles  = 0;

   // Applies one request to the shadow queue and returns the status that the
   // block must report for it. A search walks from the head and stops at the
   // first equal entry, so duplicates always report the oldest copy.
   function automatic rsp_type apply_queue_op(req_type r);
      rsp_type     o;
      int unsigned slot;
      bit          found;
      o     = '0;
      found = 1'b0;
      case (r.op)
         OP_PUSH: begin
            if (ring_count < DEPTH) begin
               ring[ring_tail] = r.value;
               ring_tail       = (ring_tail + 1) % DEPTH;
               ring_count++;
               o.ok = 1'b1;
            end
         end
         OP_POP: begin
            if (ring_count > 0) begin
               o.popped_value = ring[ring_head];
               ring_head      = (ring_head + 1) % DEPTH;
               ring_count--;
               o.ok = 1'b1;
            end
         end
         OP_SEARCH: begin
            slot = ring_head;
            for (int k = 0; k < ring_count; k++) begin
               if (!found && ring[slot] == r.value) begin
                  found      = 1'b1;
                  o.position = CNT_W'(k + 1);
                  o.ok       = 1'b1;
               end
               slot = (slot + 1) % DEPTH;
            end
         end
         default: ;
      endcase
      if (ring_count > 0)
         o.head_value = ring[ring_head];
      o.head_valid = (ring_count > 0);
      o.is_empty   = (ring_count == 0);
      o.occupancy  = CNT_W'(ring_count);
      return o;
   endfunction

   function automatic void check_field(string name, logic [DATA_W-1:0] want,
                                       logic [DATA_W-1:0] got);
      if (got !== want) begin
         $display("%0t: %s mismatch, expected %h, got %h", $time, name, want, got);
         error_count++;
      end
   endfunction

   function automatic rsp_type status(int ok, logic signed [DATA_W-1:0] popped,
                                      int pos, logic signed [DATA_W-1:0] head, int occ);
      rsp_type o;
      o.ok           = (ok != 0);
      o.popped_value = popped;
      o.position     = CNT_W'(pos);
      o.head_value   = head;
      o.head_valid   = (occ > 0);
      o.is_empty     = (occ == 0);
      o.occupancy    = CNT_W'(occ);
      return o;
   endfunction

   task automatic add_row(logic [1:0] op, logic signed [DATA_W-1:0] value, int reps,
                          int has_want, rsp_type want);
      stim_row_type row;
      row.item.op    = op;
      row.item.value = value;
      row.reps       = reps;
      row.has_want   = (has_want != 0);
      row.want       = want;
      directed_rows.push_back(row);
   endtask

   // Offers one request and waits for its transfer. Valid stays high from one
   // request to the next unless a random gap is taken, so every step gives the
   // valid signal at most one update. The expectation is recorded at the very
   // edge that takes the request, before any response to it can appear.
   task automatic send_request(req_type r, bit has_want, rsp_type want);
      rsp_type predicted;
      while ($urandom_range(99) < req_gap_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid <= 1'b1;
      req_ch.data  <= r;
      do
         @(posedge clock);
      while (!req_ch.ready);
      predicted = apply_queue_op(r);
      due_responses.push_back(has_want ? want : predicted);
   endtask

   // Random values lean on a small pool and on the extremes so that duplicates
   // and search hits are common, while full-range values exercise every bit.
   function automatic logic signed [DATA_W-1:0] pick_value();
      case ($urandom_range(3))
         0: return $signed(DATA_W'($urandom_range(7))) - 4;
         1: begin
            case ($urandom_range(3))
               0: return MAX_VALUE;
               1: return MIN_VALUE;
               2: return ALL_ONES;
               default: return '0;
            endcase
         end
         default: return $urandom;
      endcase
   endfunction

   // Mostly searches for something that is held, at a random depth, so that
   // hit positions spread across the whole queue; the rest are likely misses.
   function automatic logic signed [DATA_W-1:0] pick_search_value();
      if (ring_count > 0 && $urandom_range(99) < 60)
         return ring[(ring_head + $urandom_range(ring_count - 1)) % DEPTH];
      return pick_value();
   endfunction

   // Receiver. It stalls at random, and once, after a few hundred responses,
   // holds off for a long stretch while the sender keeps offering requests.
   // The output register and the request in flight then fill, and the block
   // has to hold its request channel. The hold-off is counted here, in cycles.
   initial begin
      bit hold_done;
      hold_done    = 1'b0;
      rsp_ch.ready = 1'b0;
      wait (!reset);
      forever begin
         @(posedge clock);
         if (rsp_ch.valid && rsp_ch.ready)
            rsp_transfers++;
         if (!hold_done && rsp_transfers >= HOLD_AFTER) begin
            hold_done    = 1'b1;
            rsp_ch.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            rsp_ch.ready <= ($urandom_range(99) >= rsp_stall_pct);
         end
      end
   end

   // Response checker: every transfer is compared, field by field, with the
   // oldest response still due.
   always @(posedge clock) begin : check_rsp
      rsp_type got;
      rsp_type want;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.data;
         if (due_responses.size() == 0) begin
            $display("%0t: response with none due, got %p", $time, got);
            error_count++;
         end else begin
            want = due_responses.pop_front();
            check_field("ok", DATA_W'(want.ok), DATA_W'(got.ok));
            check_field("popped_value", want.popped_value, got.popped_value);
            check_field("position", DATA_W'(want.position), DATA_W'(got.position));
            check_field("head_value", want.head_value, got.head_value);
            check_field("head_valid", DATA_W'(want.head_valid), DATA_W'(got.head_valid));
            check_field("is_empty", DATA_W'(want.is_empty), DATA_W'(got.is_empty));
            check_field("occupancy", DATA_W'(want.occupancy), DATA_W'(got.occupancy));
         end
      end
   end

   // Watchdog: a run that stops moving on both channels is a failure.
   always @(posedge clock) begin
      if (reset || (req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= STALL_LIMIT) begin
         $display("%0t: no transfer for %0d cycles", $time, STALL_LIMIT);
         $display("testbench: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   initial begin
      traffic_mode_type mode;
      req_type          r;
      int               real_items;
      int               span;
      int               roll;
      int               push_pct;
      int               pop_pct;

      req_ch.valid = 1'b0;
      req_ch.data  = '0;
      real_items   = 0;

      // Directed table. The queue starts empty, takes both extremes, fills to
      // the brim with duplicates, rejects one push when full, finds the very
      // last slot, and gives up its two oldest entries.
      add_row(OP_POP,    '0,        1,  1, status(0, 0, 0, 0, 0));
      add_row(OP_SEARCH, '0,        1,  1, status(0, 0, 0, 0, 0));
      add_row(OP_UNUSED, ALL_ONES,  1,  1, status(0, 0, 0, 0, 0));
      add_row(OP_PUSH,   MAX_VALUE, 1,  1, status(1, 0, 0, MAX_VALUE, 1));
      add_row(OP_PUSH,   MIN_VALUE, 1,  1, status(1, 0, 0, MAX_VALUE, 2));
      add_row(OP_SEARCH, MIN_VALUE, 1,  1, status(1, 0, 2, MAX_VALUE, 2));
      add_row(OP_SEARCH, '0,        1,  1, status(0, 0, 0, MAX_VALUE, 2));
      add_row(OP_PUSH,   ALL_ONES,  13, 0, '0);
      add_row(OP_PUSH,   32'sd1,    1,  1, status(1, 0, 0, MAX_VALUE, DEPTH));
      add_row(OP_PUSH,   '0,        1,  1, status(0, 0, 0, MAX_VALUE, DEPTH));
      add_row(OP_SEARCH, 32'sd1,    1,  1, status(1, 0, DEPTH, MAX_VALUE, DEPTH));
      add_row(OP_SEARCH, ALL_ONES,  1,  1, status(1, 0, 3, MAX_VALUE, DEPTH));
      add_row(OP_UNUSED, MAX_VALUE, 1,  1, status(0, 0, 0, MAX_VALUE, DEPTH));
      add_row(OP_POP,    '0,        1,  1, status(1, MAX_VALUE, 0, MIN_VALUE, DEPTH - 1));
      add_row(OP_POP,    '0,        1,  1, status(1, MIN_VALUE, 0, ALL_ONES, DEPTH - 2));

      repeat (10) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         repeat (directed_rows[i].reps)
            send_request(directed_rows[i].item, directed_rows[i].has_want,
                         directed_rows[i].want);

      // Random traffic in bursts. Fill bursts drive the queue into the full
      // case, drain bursts into the empty case, and mixed bursts keep it busy
      // in between. A few unused codes and random searches act as noise.
      while (real_items < RANDOM_ITEMS) begin
         mode = traffic_mode_type'($urandom_range(2));
         span = $urandom_range(8, 48);
         case (mode)
            MODE_FILL:  begin push_pct = 65; pop_pct = 15; end
            MODE_DRAIN: begin push_pct = 15; pop_pct = 65; end
            default:    begin push_pct = 35; pop_pct = 35; end
         endcase
         repeat (span) begin
            // A long stretch in the middle runs with no idling on either side.
            if (real_items >= 700 && real_items < 1000) begin
               req_gap_pct   = 0;
               rsp_stall_pct = 0;
            end else begin
               req_gap_pct   = 20;
               rsp_stall_pct = 20;
            end
            roll = $urandom_range(99);
            if (roll < push_pct) begin
               r.op    = OP_PUSH;
               r.value = pick_value();
            end else if (roll < push_pct + pop_pct) begin
               r.op    = OP_POP;
               r.value = pick_value();
            end else if (roll < 97) begin
               r.op    = OP_SEARCH;
               r.value = pick_search_value();
            end else begin
               r.op    = OP_UNUSED;
               r.value = pick_value();
            end
            send_request(r, 1'b0, '0);
            if (r.op != OP_UNUSED)
               real_items++;
         end
      end
      req_ch.valid <= 1'b0;

      // Let every due response arrive, then give the block time to show any
      // stray transfer. The watchdog bounds the wait.
      while (due_responses.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (error_count == 0 && due_responses.size() == 0)
         $display("testbench: done, clean");
      else
         $display("testbench: done, errors");
      $finish;
   end

endmodule
`default_nettype wire

[fifo_queue_with_search.f]
rtl/fqs_pkg.sv
rtl/fqs_req_if.sv
rtl/fqs_rsp_if.sv
rtl/fqs_datapath.sv
rtl/fqs_controller.sv
rtl/fifo_queue_with_search.sv
dv/testbench.sv
